FILE: rtl/sst_pkg.sv
// Shared types, codes and sizes for the sparse-set component table.
package sst_pkg;

    localparam int SLOTS       = 4096;
    localparam int IDX_BITS    = 12;
    localparam int GEN_BITS    = 10;
    localparam int HANDLE_BITS = IDX_BITS + GEN_BITS;
    localparam int ROW_BITS    = 64;
    localparam int CNT_BITS    = 13;
    localparam int PC_BITS     = 5;

    localparam logic [1:0] KIND_GET    = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ABSENT  = 3'd1,
        ST_PRESENT = 3'd2,
        ST_FULL    = 3'd3,
        ST_NULL    = 3'd4,
        ST_STALE   = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        C_NEVER    = 4'd0,
        C_ALWAYS   = 4'd1,
        C_CLR_MORE = 4'd2,
        C_KIND_BAD = 4'd3,
        C_NULL     = 4'd4,
        C_NOT_HELD = 4'd5,
        C_IS_ADD   = 4'd6,
        C_STALE    = 4'd7,
        C_IS_GET   = 4'd8,
        C_NOT_ADD  = 4'd9,
        C_FULL     = 4'd10
    } t_cond;

    typedef enum logic {
        DS_HIT  = 1'b0,
        DS_LAST = 1'b1
    } t_dense_sel;

    typedef enum logic [1:0] {
        SL_ZERO = 2'd0,
        SL_HIT  = 2'd1,
        SL_TAIL = 2'd2
    } t_slot_sel;

    typedef struct packed {
        logic [1:0]             kind;
        logic [HANDLE_BITS-1:0] entity_handle;
        logic [ROW_BITS-1:0]    row_in;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [ROW_BITS-1:0] row_out;
        logic [IDX_BITS-1:0] dense_slot;
        logic [CNT_BITS-1:0] entry_count;
    } t_out_item;

    // One microcode word.
    typedef struct packed {
        logic               take_in;
        logic               do_clear;
        logic               rd_sparse;
        logic               rd_dense;
        t_dense_sel         dense_sel;
        logic               do_add;
        logic               do_remove;
        logic               emit;
        t_status            status;
        logic               emit_row;
        t_slot_sel          slot_sel;
        t_cond              cond;
        logic [PC_BITS-1:0] target;
    } t_ctrl;

    // Datapath conditions seen by the sequencer.
    typedef struct packed {
        logic out_busy;
        logic clr_more;
        logic kind_bad;
        logic null_h;
        logic not_held;
        logic is_add;
        logic is_get;
        logic not_add;
        logic stale;
        logic full;
    } t_flags;

endpackage

FILE: rtl/sst_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module sst_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sst_pkg::t_flags i_flags,
    input  logic            i_in_valid,
    output sst_pkg::t_ctrl  o_ctrl,
    output logic            o_go
);
    import sst_pkg::*;

    localparam logic [PC_BITS-1:0] L_CLEAR       = 5'd0;
    localparam logic [PC_BITS-1:0] L_FETCH       = 5'd1;
    localparam logic [PC_BITS-1:0] L_SCREEN_KIND = 5'd2;
    localparam logic [PC_BITS-1:0] L_SCREEN_NULL = 5'd3;
    localparam logic [PC_BITS-1:0] L_RD_MAP      = 5'd4;
    localparam logic [PC_BITS-1:0] L_RD_HIT      = 5'd5;
    localparam logic [PC_BITS-1:0] L_CHK_HELD    = 5'd6;
    localparam logic [PC_BITS-1:0] L_CHK_ADD     = 5'd7;
    localparam logic [PC_BITS-1:0] L_CHK_STALE   = 5'd8;
    localparam logic [PC_BITS-1:0] L_CHK_GET     = 5'd9;
    localparam logic [PC_BITS-1:0] L_RD_LAST     = 5'd10;
    localparam logic [PC_BITS-1:0] L_REMOVE      = 5'd11;
    localparam logic [PC_BITS-1:0] L_GET         = 5'd12;
    localparam logic [PC_BITS-1:0] L_NOT_HELD    = 5'd13;
    localparam logic [PC_BITS-1:0] L_CHK_FULL    = 5'd14;
    localparam logic [PC_BITS-1:0] L_ADD         = 5'd15;
    localparam logic [PC_BITS-1:0] L_ABSENT      = 5'd16;
    localparam logic [PC_BITS-1:0] L_NULL        = 5'd17;
    localparam logic [PC_BITS-1:0] L_PRESENT     = 5'd18;
    localparam logic [PC_BITS-1:0] L_STALE       = 5'd19;
    localparam logic [PC_BITS-1:0] L_FULL        = 5'd20;

    function automatic t_ctrl f_ucode(input logic [PC_BITS-1:0] pc);
        t_ctrl w;
        w          = '0;
        w.cond     = C_NEVER;
        w.status   = ST_OK;
        w.slot_sel = SL_ZERO;
        case (pc)
            L_CLEAR: begin
                w.do_clear = 1'b1;
                w.cond     = C_CLR_MORE;
                w.target   = L_CLEAR;
            end
            L_FETCH:       w.take_in = 1'b1;
            L_SCREEN_KIND: begin
                w.cond   = C_KIND_BAD;
                w.target = L_ABSENT;
            end
            L_SCREEN_NULL: begin
                w.cond   = C_NULL;
                w.target = L_NULL;
            end
            L_RD_MAP:      w.rd_sparse = 1'b1;
            L_RD_HIT: begin
                w.rd_dense  = 1'b1;
                w.dense_sel = DS_HIT;
            end
            L_CHK_HELD: begin
                w.cond   = C_NOT_HELD;
                w.target = L_NOT_HELD;
            end
            L_CHK_ADD: begin
                w.cond   = C_IS_ADD;
                w.target = L_PRESENT;
            end
            L_CHK_STALE: begin
                w.cond   = C_STALE;
                w.target = L_STALE;
            end
            L_CHK_GET: begin
                w.cond   = C_IS_GET;
                w.target = L_GET;
            end
            L_RD_LAST: begin
                w.rd_dense  = 1'b1;
                w.dense_sel = DS_LAST;
            end
            L_REMOVE: begin
                w.do_remove = 1'b1;
                w.emit      = 1'b1;
                w.slot_sel  = SL_HIT;
                w.cond      = C_ALWAYS;
                w.target    = L_FETCH;
            end
            L_GET: begin
                w.emit     = 1'b1;
                w.emit_row = 1'b1;
                w.slot_sel = SL_HIT;
                w.cond     = C_ALWAYS;
                w.target   = L_FETCH;
            end
            L_NOT_HELD: begin
                w.cond   = C_NOT_ADD;
                w.target = L_ABSENT;
            end
            L_CHK_FULL: begin
                w.cond   = C_FULL;
                w.target = L_FULL;
            end
            L_ADD: begin
                w.do_add   = 1'b1;
                w.emit     = 1'b1;
                w.slot_sel = SL_TAIL;
                w.cond     = C_ALWAYS;
                w.target   = L_FETCH;
            end
            L_ABSENT: begin
                w.emit   = 1'b1;
                w.status = ST_ABSENT;
                w.cond   = C_ALWAYS;
                w.target = L_FETCH;
            end
            L_NULL: begin
                w.emit   = 1'b1;
                w.status = ST_NULL;
                w.cond   = C_ALWAYS;
                w.target = L_FETCH;
            end
            L_PRESENT: begin
                w.emit   = 1'b1;
                w.status = ST_PRESENT;
                w.cond   = C_ALWAYS;
                w.target = L_FETCH;
            end
            L_STALE: begin
                w.emit   = 1'b1;
                w.status = ST_STALE;
                w.cond   = C_ALWAYS;
                w.target = L_FETCH;
            end
            L_FULL: begin
                w.emit   = 1'b1;
                w.status = ST_FULL;
                w.cond   = C_ALWAYS;
                w.target = L_FETCH;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = L_FETCH;
            end
        endcase
        return w;
    endfunction

    logic [PC_BITS-1:0] r_pc;
    logic [PC_BITS-1:0] n_pc;
    t_ctrl              w_word;
    logic               w_taken;
    logic               w_go;

    assign w_word = f_ucode(r_pc);

    always_comb begin
        case (w_word.cond)
            C_NEVER:    w_taken = 1'b0;
            C_ALWAYS:   w_taken = 1'b1;
            C_CLR_MORE: w_taken = i_flags.clr_more;
            C_KIND_BAD: w_taken = i_flags.kind_bad;
            C_NULL:     w_taken = i_flags.null_h;
            C_NOT_HELD: w_taken = i_flags.not_held;
            C_IS_ADD:   w_taken = i_flags.is_add;
            C_STALE:    w_taken = i_flags.stale;
            C_IS_GET:   w_taken = i_flags.is_get;
            C_NOT_ADD:  w_taken = i_flags.not_add;
            C_FULL:     w_taken = i_flags.full;
            default:    w_taken = 1'b0;
        endcase
    end

    // A step holds while it waits for an input transfer or for room at the output.
    assign w_go = !(w_word.take_in && !i_in_valid) && !(w_word.emit && i_flags.out_busy);

    always_comb begin
        n_pc = r_pc;
        if (w_go) begin
            n_pc = w_taken ? w_word.target : r_pc + PC_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_word;
    assign o_go   = w_go;

endmodule

FILE: rtl/sst_dp.sv
// Datapath: sparse, owner and row memories, row count and result register.
module sst_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sst_pkg::t_ctrl     i_ctrl,
    input  logic               i_go,
    input  sst_pkg::t_in_item  i_in,
    input  logic               i_out_ready,
    output sst_pkg::t_flags    o_flags,
    output logic               o_out_valid,
    output sst_pkg::t_out_item o_out
);
    import sst_pkg::*;

    logic [IDX_BITS-1:0]    r_sparse_mem [SLOTS];
    logic [HANDLE_BITS-1:0] r_owner_mem  [SLOTS];
    logic [ROW_BITS-1:0]    r_row_mem    [SLOTS];

    logic [1:0]             r_kind;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [ROW_BITS-1:0]    r_row_in;
    logic [IDX_BITS-1:0]    r_sparse_q;
    logic [HANDLE_BITS-1:0] r_owner_q;
    logic [ROW_BITS-1:0]    r_row_q;
    logic [IDX_BITS-1:0]    r_d;
    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    n_count;
    logic [IDX_BITS-1:0]    r_clr;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [IDX_BITS-1:0]    w_idx;
    logic [IDX_BITS-1:0]    w_tail;
    logic [IDX_BITS-1:0]    w_last;
    logic [IDX_BITS-1:0]    w_rd_addr;
    logic                   w_clear;
    logic                   w_add;
    logic                   w_remove;
    logic                   w_sp_we;
    logic [IDX_BITS-1:0]    w_sp_addr;
    logic [IDX_BITS-1:0]    w_sp_data;
    logic [IDX_BITS-1:0]    w_dn_addr;
    logic [IDX_BITS-1:0]    w_slot;

    assign w_idx     = r_handle[IDX_BITS-1:0];
    assign w_tail    = r_count[IDX_BITS-1:0];
    assign w_last    = IDX_BITS'(r_count - CNT_BITS'(1));
    assign w_rd_addr = (i_ctrl.dense_sel == DS_LAST) ? w_last : r_sparse_q;
    assign w_clear   = i_ctrl.do_clear && i_go;
    assign w_add     = i_ctrl.do_add && i_go;
    assign w_remove  = i_ctrl.do_remove && i_go;

    // Sparse port: clearing sweep, new entry, or repoint of the moved tail owner.
    always_comb begin
        w_sp_we   = w_clear || w_add || w_remove;
        w_sp_addr = r_owner_q[IDX_BITS-1:0];
        w_sp_data = r_d;
        if (w_clear) begin
            w_sp_addr = r_clr;
            w_sp_data = '1;
        end else if (w_add) begin
            w_sp_addr = w_idx;
            w_sp_data = w_tail;
        end
    end

    assign w_dn_addr = w_add ? w_tail : r_d;

    always_ff @(posedge i_clk) begin
        if (w_sp_we) begin
            r_sparse_mem[w_sp_addr] <= w_sp_data;
        end
        if (i_ctrl.rd_sparse && i_go) begin
            r_sparse_q <= r_sparse_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_add || w_remove) begin
            r_owner_mem[w_dn_addr] <= w_add ? r_handle : r_owner_q;
            r_row_mem[w_dn_addr]   <= w_add ? r_row_in : r_row_q;
        end
        if (i_ctrl.rd_dense && i_go) begin
            r_owner_q <= r_owner_mem[w_rd_addr];
            r_row_q   <= r_row_mem[w_rd_addr];
        end
    end

    // Item and hit position registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_in && i_go) begin
            r_kind   <= i_in.kind;
            r_handle <= i_in.entity_handle;
            r_row_in <= i_in.row_in;
        end
        if (i_ctrl.rd_dense && i_go && i_ctrl.dense_sel == DS_HIT) begin
            r_d <= r_sparse_q;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_add) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (w_remove) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_comb begin
        case (i_ctrl.slot_sel)
            SL_ZERO: w_slot = '0;
            SL_HIT:  w_slot = r_d;
            SL_TAIL: w_slot = w_tail;
            default: w_slot = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_clear) begin
                r_clr <= r_clr + IDX_BITS'(1);
            end
            if (i_ctrl.emit && i_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit && i_go) begin
            r_out.status      <= i_ctrl.status;
            r_out.row_out     <= i_ctrl.emit_row ? r_row_q : '0;
            r_out.dense_slot  <= w_slot;
            r_out.entry_count <= n_count;
        end
    end

    // An entry is held only if its slot is below the count and that slot's
    // owner carries the same index; stale map words never pass both.
    always_comb begin
        o_flags          = '0;
        o_flags.out_busy = r_out_valid && !i_out_ready;
        o_flags.clr_more = ~&r_clr;
        o_flags.kind_bad = (r_kind == KIND_BAD);
        o_flags.null_h   = (r_handle == '0);
        o_flags.not_held = !({1'b0, r_d} < r_count)
                           || (r_owner_q[IDX_BITS-1:0] != w_idx);
        o_flags.is_add   = (r_kind == KIND_ADD);
        o_flags.is_get   = (r_kind == KIND_GET);
        o_flags.not_add  = (r_kind != KIND_ADD);
        o_flags.stale    = (r_owner_q != r_handle);
        o_flags.full     = (r_count == CNT_BITS'(SLOTS));
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/sparse_set_component_table_core.sv
// Top level of the sparse-set component table: sequencer plus datapath.
//
// Maps entity handles (12-bit index, 10-bit generation, zero is null) onto a
// packed array of 4096 rows; each transfer in is a get, add or remove (any
// other kind is refused as absent) and gives exactly one result transfer
// out. One item is worked at a time by a microcoded sequencer over
// single-port memories, so each item walks as much of the memory read chain
// as it needs in turn (map, then owner and row, then the tail row on remove)
// before its result is ready, and a step that emits waits for the output
// register to drain. A result may sit in the output register while the next
// item is taken in. After reset the block sweeps all 4096 words of the map
// memory once before its first input transfer.
module sparse_set_component_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sst_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sst_pkg::t_out_item o_out
);
    import sst_pkg::*;

    t_ctrl  w_ctrl;
    t_flags w_flags;
    logic   w_go;

    sst_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flags    (w_flags),
        .i_in_valid (i_in_valid),
        .o_ctrl     (w_ctrl),
        .o_go       (w_go)
    );

    sst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_go        (w_go),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .o_flags     (w_flags),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign o_in_ready = w_ctrl.take_in;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.entry_count <= CNT_BITS'(SLOTS))
        else $error("entry count above capacity");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK)
            |-> (o_out.row_out == '0 && o_out.dense_slot == '0))
        else $error("refused operation carries row or slot");

    a_ok_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_OK)
            |-> ({1'b0, o_out.dense_slot} <= o_out.entry_count))
        else $error("dense slot beyond held rows");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transfer taken while an item is in work");
`endif

endmodule
